// File: sv/bps_pkg.sv
// Shared types and constants for the byte pattern search block.
// No dependencies; compiled first.
package bps_pkg;

  localparam int MAX_PATTERN = 63;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int ADDR_W      = 32;
  localparam int SEEN_W      = 33;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_MEMORY  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_REGION_SIZE    = 2'd1,
    CFG_BASE_ADDRESS   = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  // write into the reversed pattern copy held by the cells
  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } qwr_t;

  typedef struct packed {
    logic              shift;
    logic              q_we;
    logic [BYTE_W-1:0] q_data;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } res_t;

endpackage

// File: sv/bps_ifs.sv
// Valid/ready channel interfaces: input items, results, configuration writes.
// Depends on bps_pkg.
interface bps_in_if;
  logic                      valid;
  logic                      ready;
  bps_pkg::kind_t            kind;
  logic [bps_pkg::LEN_W-1:0] pattern_index;
  logic [bps_pkg::BYTE_W-1:0] value;
  logic                      last;
  modport source(output valid, kind, pattern_index, value, last, input ready);
  modport sink(input valid, kind, pattern_index, value, last, output ready);
endinterface

interface bps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bps_pkg::ADDR_W-1:0] match_address;
  modport source(output valid, found, match_address, input ready);
  modport sink(input valid, found, match_address, output ready);
endinterface

interface bps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [bps_pkg::CFG_DATA_W-1:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

// File: sv/byte_pattern_search.sv
// Byte pattern search: first match of a loaded byte pattern in a byte stream.
// Channels: in_chan takes pattern loads (kind 0, by index) and memory bytes
// (kind 1, last marks the final byte); out_chan gives found and
// match_address; cfg_chan writes pattern_length (0), region_size (1) and
// base_address (2) and is always ready.
// Throughput: one input transfer per cycle while in_chan.ready is high.
// A byte's result, if any, is registered into the result queue and reaches
// out_chan behind any waiting results. A search gives one result: the first
// match, or found = 0 at the last byte; last clears the search state.
// Matching runs in a chain of 63 cells holding the window and a reversed copy
// of the pattern. Writing pattern_length starts a rebuild of that copy, during
// which in_chan.ready is low. Reset: no search in progress, pattern_length 1,
// region and base 0; pattern contents stay undefined until loaded.
// A two-entry result queue lets input flow while a result waits; if the
// receiver stalls with both entries full, in_chan.ready drops.
// Depends on bps_pkg, bps_ifs, bps_cell, bps_pattern, bps_out_q.
module byte_pattern_search (
  input  logic       clk,
  input  logic       rst_n,
  bps_in_if.sink     in_chan,
  bps_out_if.source  out_chan,
  bps_cfg_if.sink    cfg_chan
);
  import bps_pkg::*;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] region_r;
  logic [ADDR_W-1:0] base_r;
  logic [SEEN_W-1:0] seen_r;
  logic              match_r;

  logic              cfg_acc, in_acc, mem_acc, pat_acc, len_wr;
  logic              q_full, busy, push, hit_now, all_hit, len_ok;
  logic [SEEN_W-1:0] seen_inc, start;
  qwr_t              qwr;
  res_t              res;

  logic [BYTE_W-1:0]      chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hit;

  assign cfg_chan.ready = 1'b1;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign len_wr  = cfg_acc && (cfg_chan.reg_index == CFG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      region_r <= '0;
      base_r   <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_idx_t'(cfg_chan.reg_index))
        CFG_PATTERN_LENGTH: len_r    <= cfg_chan.wdata[LEN_W-1:0];
        CFG_REGION_SIZE:    region_r <= cfg_chan.wdata[ADDR_W-1:0];
        CFG_BASE_ADDRESS:   base_r   <= cfg_chan.wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready = !q_full && !busy;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign mem_acc = in_acc && (in_chan.kind == KIND_MEMORY);
  assign pat_acc = in_acc && (in_chan.kind == KIND_PATTERN);

  bps_pattern u_pattern (
    .clk      (clk),
    .rst_n    (rst_n),
    .pat_we   (pat_acc),
    .pat_idx  (in_chan.pattern_index),
    .pat_data (in_chan.value),
    .len_wr   (len_wr),
    .len      (len_r),
    .qwr      (qwr),
    .busy     (busy)
  );

  assign chain[0] = in_chan.value;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    cell_ctl_t ctl;
    logic      active;
    assign ctl.shift  = mem_acc;
    assign ctl.q_we   = qwr.we && (qwr.addr == PIDX_W'(j));
    assign ctl.q_data = qwr.data;
    assign active     = (LEN_W'(j) < len_r);
    bps_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .active   (active),
      .byte_in  (chain[j]),
      .byte_out (chain[j+1]),
      .hit      (hit[j])
    );
  end

  assign all_hit  = &hit;
  assign len_ok   = (len_r != '0) && (int'(len_r) <= MAX_PATTERN);
  assign seen_inc = (seen_r == SEEN_MAX) ? seen_r : seen_r + SEEN_W'(1);
  assign start    = seen_inc - SEEN_W'(len_r);
  assign hit_now  = !match_r && len_ok && (seen_inc >= SEEN_W'(len_r)) &&
                    (start < SEEN_W'(region_r)) && all_hit;

  always_comb begin
    res = '0;
    if (hit_now) begin
      res.found         = 1'b1;
      res.match_address = base_r + start[ADDR_W-1:0];
    end
  end

  assign push = mem_acc && (hit_now || (in_chan.last && !match_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      match_r <= 1'b0;
    end else if (mem_acc) begin
      if (in_chan.last) begin
        seen_r  <= '0;
        match_r <= 1'b0;
      end else begin
        seen_r <= seen_inc;
        if (hit_now) begin
          match_r <= 1'b1;
        end
      end
    end
  end

  bps_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (q_full),
    .out_chan  (out_chan)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("result pushed into full queue");

  a_no_input_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_acc)
    else $error("input transfer during pattern rebuild");

  a_match_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_acc && hit_now && !in_chan.last) |=> match_r)
    else $error("match not recorded");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_acc && in_chan.last) |=> (seen_r == '0) && !match_r)
    else $error("search state not cleared after last byte");

endmodule

// File: sv/bps_cell.sv
// One window cell: a stream byte that shifts on to the neighbor and the
// pattern byte aligned to it. Depends on bps_pkg.
module bps_cell (
  input  logic                       clk,
  input  bps_pkg::cell_ctl_t         ctl,
  input  logic                       active,
  input  logic [bps_pkg::BYTE_W-1:0] byte_in,
  output logic [bps_pkg::BYTE_W-1:0] byte_out,
  output logic                       hit
);
  import bps_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= byte_in;
    end
    if (ctl.q_we) begin
      q_r <= ctl.q_data;
    end
  end

  // byte_in is the value this cell holds after the shift
  assign hit      = !active || (byte_in == q_r);
  assign byte_out = win_r;

endmodule

// File: sv/bps_pattern.sv
// Pattern store and the sequencer that keeps the cells' reversed pattern
// copy in line with pattern_length. Depends on bps_pkg.
module bps_pattern (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pat_we,
  input  logic [bps_pkg::LEN_W-1:0]  pat_idx,
  input  logic [bps_pkg::BYTE_W-1:0] pat_data,
  input  logic                       len_wr,
  input  logic [bps_pkg::LEN_W-1:0]  len,
  output bps_pkg::qwr_t              qwr,
  output logic                       busy
);
  import bps_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_PATTERN];
  logic [BYTE_W-1:0] rd_data_r;
  logic [PIDX_W-1:0] sweep_idx_r;
  logic [PIDX_W-1:0] wr_addr_r;
  logic              sweep_r;
  logic              wr_pend_r;
  logic              direct;

  always_ff @(posedge clk) begin
    if (pat_we && (int'(pat_idx) < MAX_PATTERN)) begin
      mem[pat_idx[PIDX_W-1:0]] <= pat_data;
    end
    rd_data_r <= mem[sweep_idx_r];
  end

  // rebuild pass: read entry i, next cycle write it to slot len-1-i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      sweep_idx_r <= '0;
      wr_addr_r   <= '0;
    end else if (len_wr) begin
      sweep_r     <= 1'b1;
      wr_pend_r   <= 1'b0;
      sweep_idx_r <= '0;
    end else if (sweep_r) begin
      if (len == '0) begin
        sweep_r   <= 1'b0;
        wr_pend_r <= 1'b0;
      end else begin
        wr_pend_r   <= 1'b1;
        wr_addr_r   <= PIDX_W'(len - LEN_W'(1) - LEN_W'(sweep_idx_r));
        sweep_idx_r <= sweep_idx_r + 1'b1;
        if (LEN_W'(sweep_idx_r) == len - LEN_W'(1)) begin
          sweep_r <= 1'b0;
        end
      end
    end else begin
      wr_pend_r <= 1'b0;
    end
  end

  assign direct = pat_we && (pat_idx < len);
  assign busy   = sweep_r || wr_pend_r;

  always_comb begin
    qwr = '0;
    if (wr_pend_r) begin
      qwr.we   = 1'b1;
      qwr.addr = wr_addr_r;
      qwr.data = rd_data_r;
    end else if (direct) begin
      qwr.we   = 1'b1;
      qwr.addr = PIDX_W'(len - LEN_W'(1) - pat_idx);
      qwr.data = pat_data;
    end
  end

endmodule

// File: sv/bps_out_q.sv
// Two-entry result queue between the search logic and the result channel.
// Depends on bps_pkg and bps_ifs.
module bps_out_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bps_pkg::res_t   push_data,
  output logic            full,
  bps_out_if.source       out_chan
);
  import bps_pkg::*;

  res_t       e0_r, e1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop  = out_chan.valid && out_chan.ready;
  assign full = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b11: begin
          if (cnt_r == 2'd1) begin
            e0_r <= push_data;
          end else begin
            e0_r <= e1_r;
            e1_r <= push_data;
          end
        end
        2'b01: begin
          e0_r  <= e1_r;
          cnt_r <= cnt_r - 2'd1;
        end
        2'b10: begin
          if (cnt_r == 2'd0) begin
            e0_r <= push_data;
          end else begin
            e1_r <= push_data;
          end
          cnt_r <= cnt_r + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.found         = e0_r.found;
  assign out_chan.match_address = e0_r.match_address;

endmodule
